### rtl/core/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants for the Modbus read-response parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

    localparam int SLOT_MAX        = 4;
    localparam int SLOT_COUNT_DEF  = 4;
    localparam int FRAME_BYTES_DEF = 13;

    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [3:0]  FRAME_OVERHEAD    = 4'd5;
    localparam logic [7:0]  ADDR_RESET        = 8'h0A;

    localparam int          PADDR_W      = 3;
    localparam logic [0:0]  REG_SLAVE_ADDR = 1'b0;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_FUNC,
        PH_COUNT,
        PH_BODY
    } t_phase;

    typedef struct packed {
        logic                      crc_ok;
        logic [2:0]                value_count;
        logic [SLOT_MAX-1:0][15:0] slots;
        logic [31:0]               frames;
    } t_result;

endpackage

### rtl/core/mrp_crc16.sv
// ----------------------------------------------------------------------------
// mrp_crc16
// One-byte update of the reflected CRC-16 used by Modbus RTU.
// ----------------------------------------------------------------------------
module mrp_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mrp_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'h00, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

### rtl/core/mrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// mrp_cfg_regs
// APB register bank holding the slave address.
// ----------------------------------------------------------------------------
module mrp_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output logic [7:0]                  o_slave_addr
);
    import mrp_pkg::*;

    logic [7:0] r_slave_addr;
    logic [7:0] n_slave_addr;
    logic       sel_addr;

    assign sel_addr = (paddr[PADDR_W-1:2] == REG_SLAVE_ADDR);

    always_comb begin
        n_slave_addr = r_slave_addr;
        if (psel && penable && pwrite && sel_addr) begin
            n_slave_addr = pwdata[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= ADDR_RESET;
        end else begin
            r_slave_addr <= n_slave_addr;
        end
    end

    assign prdata       = sel_addr ? {24'h000000, r_slave_addr} : 32'h0;
    assign pready       = 1'b1;
    assign o_slave_addr = r_slave_addr;

endmodule

### rtl/core/mrp_frame_parser.sv
// ----------------------------------------------------------------------------
// mrp_frame_parser
// Byte-at-a-time frame hunt with running CRC, data staging and slot update.
// ----------------------------------------------------------------------------
module mrp_frame_parser #(
    parameter int SLOT_COUNT  = mrp_pkg::SLOT_COUNT_DEF,
    parameter int FRAME_BYTES = mrp_pkg::FRAME_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic [7:0]       i_slave_addr,
    output logic             o_res_valid,
    output mrp_pkg::t_result o_res
);
    import mrp_pkg::*;

    localparam int DATA_BYTES = 2 * SLOT_COUNT;
    localparam int DIDX_W     = $clog2(DATA_BYTES);
    localparam int MAX_BC     = (DATA_BYTES < FRAME_BYTES - 5) ? DATA_BYTES
                                                               : FRAME_BYTES - 5;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_pos,    n_pos;
    logic [3:0]  r_len,    n_len;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [2:0]  r_count,  n_count;
    logic [31:0] r_frames, n_frames;
    logic [7:0]  r_data [DATA_BYTES];
    logic [7:0]  n_data [DATA_BYTES];
    logic [15:0] r_slot [SLOT_COUNT];
    logic [15:0] n_slot [SLOT_COUNT];

    logic [15:0] crc_in;
    logic [15:0] crc_next;
    logic [3:0]  pos_off;
    logic [4:0]  pos_ahead;
    logic        count_ok;
    logic        crc_match;

    assign crc_in = (r_phase == PH_ADDR) ? CRC_INIT : r_crc;

    mrp_crc16 u_crc (
        .i_crc  (crc_in),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    assign pos_off   = r_pos - 4'd3;
    assign pos_ahead = {1'b0, r_pos} + 5'd2;
    assign count_ok  = (i_byte != 8'h00) && !i_byte[0] && (i_byte <= 8'(MAX_BC));
    assign crc_match = ({i_byte, r_crc_lo} == r_crc);

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_len       = r_len;
        n_crc       = r_crc;
        n_crc_lo    = r_crc_lo;
        n_count     = r_count;
        n_frames    = r_frames;
        n_data      = r_data;
        n_slot      = r_slot;
        o_res_valid = 1'b0;
        o_res.crc_ok      = 1'b0;
        if (i_accept) begin
            unique case (r_phase)
                PH_ADDR: begin
                    if (i_byte == i_slave_addr) begin
                        n_crc   = crc_next;
                        n_phase = PH_FUNC;
                    end
                end
                PH_FUNC: begin
                    if (i_byte == FUNC_READ_HOLDING) begin
                        n_crc   = crc_next;
                        n_phase = PH_COUNT;
                    end else begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_COUNT: begin
                    if (count_ok) begin
                        n_crc   = crc_next;
                        n_len   = i_byte[3:0] + FRAME_OVERHEAD;
                        n_count = i_byte[3:1];
                        n_pos   = 4'd3;
                        n_phase = PH_BODY;
                    end else begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_BODY: begin
                    n_pos = r_pos + 4'd1;
                    if (pos_ahead < {1'b0, r_len}) begin
                        n_crc = crc_next;
                        n_data[pos_off[DIDX_W-1:0]] = i_byte;
                    end else if (pos_ahead == {1'b0, r_len}) begin
                        n_crc_lo = i_byte;
                    end else begin
                        // Last CRC byte: the frame is complete.
                        o_res_valid  = 1'b1;
                        o_res.crc_ok = crc_match;
                        n_phase      = PH_ADDR;
                        if (crc_match) begin
                            for (int k = 0; k < SLOT_COUNT; k++) begin
                                if (3'(k) < r_count) begin
                                    n_slot[k] = {r_data[2*k], r_data[2*k+1]};
                                end
                            end
                            n_frames = r_frames + 32'd1;
                        end
                    end
                end
                default: begin
                    n_phase = PH_ADDR;
                end
            endcase
        end
        o_res.value_count = r_count;
        o_res.frames      = n_frames;
        // Slots beyond the configured count are never written and read as zero.
        o_res.slots       = '0;
        for (int k = 0; k < SLOT_COUNT; k++) begin
            o_res.slots[k] = n_slot[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR;
            r_frames <= 32'd0;
            for (int k = 0; k < SLOT_COUNT; k++) begin
                r_slot[k] <= 16'h0000;
            end
        end else begin
            r_phase  <= n_phase;
            r_frames <= n_frames;
            r_slot   <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_crc    <= n_crc;
        r_crc_lo <= n_crc_lo;
        r_count  <= n_count;
        r_data   <= n_data;
    end

endmodule

### rtl/core/modbus_read_response_parser_core.sv
// A result is registered and appears on the output in the cycle after the last CRC byte is taken.
// One byte per cycle while no result is held back; the running CRC is updated by a byte-wide unrolled step.
// Input is stalled only while a finished result waits on the output register.
// Reset (synchronous, active low) returns to address hunting, clears the slots,
// the frame counter and the output register, and sets the slave address to 0x0A.
// ----------------------------------------------------------------------------
// modbus_read_response_parser_core
// Top level: configuration registers, frame parser and output register.
// ----------------------------------------------------------------------------
module modbus_read_response_parser_core #(
    parameter int SLOT_COUNT  = mrp_pkg::SLOT_COUNT_DEF,
    parameter int FRAME_BYTES = mrp_pkg::FRAME_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_crc_ok,
    output logic [2:0]                  o_value_count,
    output logic signed [15:0]          o_slot0_value,
    output logic signed [15:0]          o_slot1_value,
    output logic signed [15:0]          o_slot2_value,
    output logic signed [15:0]          o_slot3_value,
    output logic [31:0]                 o_frames_accepted
);
    import mrp_pkg::*;

    logic [7:0] slave_addr;
    logic     accept;
    logic     res_valid;
    t_result  res;
    logic     r_out_valid, n_out_valid;
    t_result  r_res;

    mrp_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_slave_addr (slave_addr)
    );

    // A new item may enter whenever the output register is free or being drained.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    mrp_frame_parser #(
        .SLOT_COUNT  (SLOT_COUNT),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_rx_byte),
        .i_slave_addr (slave_addr),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = res_valid;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (accept && res_valid) begin
            r_res <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_crc_ok          = r_res.crc_ok;
    assign o_value_count     = r_res.value_count;
    assign o_slot0_value     = $signed(r_res.slots[0]);
    assign o_slot1_value     = $signed(r_res.slots[1]);
    assign o_slot2_value     = $signed(r_res.slots[2]);
    assign o_slot3_value     = $signed(r_res.slots[3]);
    assign o_frames_accepted = r_res.frames;

endmodule

### rtl/core/mrp_checker.sv
// ----------------------------------------------------------------------------
// mrp_checker
// Port-level assertions for the parser core, bound to the top level.
// ----------------------------------------------------------------------------
module mrp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic               o_crc_ok,
    input logic [2:0]         o_value_count,
    input logic signed [15:0] o_slot0_value,
    input logic [31:0]        o_frames_accepted,
    input logic               pready
);

    // A waiting result holds its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_crc_ok) && $stable(o_value_count)
            && $stable(o_slot0_value) && $stable(o_frames_accepted))
        else $error("stalled result changed");

    // The input side is only held back by a result that is not being taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("input stalled without output back-pressure");

    // Every completed frame carries between one and four values.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_value_count != 3'd0) && (o_value_count <= 3'd4))
        else $error("value count out of range");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && pready)
        else $error("result visible after reset");

endmodule

bind modbus_read_response_parser_core mrp_checker u_mrp_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_crc_ok          (o_crc_ok),
    .o_value_count     (o_value_count),
    .o_slot0_value     (o_slot0_value),
    .o_frames_accepted (o_frames_accepted),
    .pready            (pready)
);
